[src/order_book_depth_aggregator_defines.svh]
// Assertion macros shared by the order book depth aggregator RTL.
// Users must have signals named clock and reset in scope.
`ifndef ORDER_BOOK_DEPTH_AGGREGATOR_DEFINES_SVH
`define ORDER_BOOK_DEPTH_AGGREGATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define OBDA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define OBDA_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/obda_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the order book depth aggregator.
// No dependencies; imported by the interfaces and all modules.
package obda_pkg;

   // Field widths of the request and response beats
   localparam int CMD_W    = 2;
   localparam int PRICE_W  = 10;
   localparam int VOL_IN_W = 16;
   localparam int VOL_W    = 32;
   localparam int DEPTH_W  = 6;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REPORT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   // Side codes
   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   // One book RAM word: touched flag and saturating volume sum
   typedef struct packed {
      logic             present;
      logic [VOL_W-1:0] volume;
   } book_entry_type;

   // Operation handed to the shared adder
   typedef struct packed {
      logic [VOL_W-1:0] a;
      logic [VOL_W-1:0] b;
      logic             sat;
   } alu_op_type;

endpackage

[src/obda_if.sv]
`timescale 1ns / 1ps
// Request and response channel interfaces (valid/ready handshake).
// Depends on obda_pkg for the field widths.
interface obda_req_if import obda_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic                side;
   logic [PRICE_W-1:0]  price;
   logic [VOL_IN_W-1:0] volume;

   modport source (output valid, command, side, price, volume, input ready);
   modport sink   (input valid, command, side, price, volume, output ready);
endinterface

interface obda_rsp_if import obda_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               side_res;
   logic [PRICE_W-1:0] price_res;
   logic [VOL_W-1:0]   volume_res;
   logic               empty_res;
   logic               last;

   modport source (output valid, side_res, price_res, volume_res, empty_res, last,
                   input ready);
   modport sink   (input valid, side_res, price_res, volume_res, empty_res, last,
                   output ready);
endinterface

[src/order_book_depth_aggregator.sv]
`timescale 1ns / 1ps
// Order book depth aggregator top level: depth register and sequencer.
// Depends on obda_pkg, obda_if and obda_seq.
//
//   channel   dir  fields                                          beat when
//   req_chan  in   command side price volume                       valid & ready
//   rsp_chan  out  side_res price_res volume_res empty_res last    valid & ready
//   csr_*     in   csr_wr_data (depth)                             csr_wr_en
//
// Add: book RAM read, then saturating write through the shared adder.
// Report: ascending sell scan, then per reported sell level a pick buffer read, a book read and an emit,
//   then a descending buy scan and a final step.
// Clear and reset: a pass over every book RAM word, during which req_chan.ready stays low.
// A stalled rsp_chan holds the scan; one level waits in a hold register, one in the output.
module order_book_depth_aggregator import obda_pkg::*; #(
   parameter int PRICE_LEVELS = 1024,
   parameter int MAX_DEPTH    = 32
) (
   input  logic               clock,
   input  logic               reset,
   obda_req_if.sink           req_chan,
   obda_rsp_if.source         rsp_chan,
   input  logic               csr_wr_en,
   input  logic [DEPTH_W-1:0] csr_wr_data
);

   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam logic [DEPTH_W-1:0] MAX_D = DEPTH_W'(MAX_DEPTH);

   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [DEPTH_W-1:0] depth_clamp;
   logic [DW-1:0]      depth_eff;

   // depth register
   assign depth_in = csr_wr_en ? csr_wr_data : depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_W'(1);
      end else begin
         depth_ff <= depth_in;
      end
   end

   // zero counts as one, large values stop at MAX_DEPTH
   assign depth_clamp = (depth_ff == '0) ? DEPTH_W'(1) :
                        (depth_ff > MAX_D) ? MAX_D : depth_ff;
   assign depth_eff   = depth_clamp[DW-1:0];

   obda_seq #(
      .PRICE_LEVELS (PRICE_LEVELS),
      .MAX_DEPTH    (MAX_DEPTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .depth_eff (depth_eff)
   );

endmodule

[src/obda_alu.sv]
`timescale 1ns / 1ps
// Shared 32-bit adder: saturating volume sums and pointer steps.
// Depends on obda_pkg for alu_op_type.
module obda_alu import obda_pkg::*; (
   input  alu_op_type       op,
   output logic [VOL_W-1:0] res
);

   logic [VOL_W:0] sum;

   // carry out means overflow when saturating
   assign sum = {1'b0, op.a} + {1'b0, op.b};
   assign res = (op.sat && sum[VOL_W]) ? '1 : sum[VOL_W-1:0];

endmodule

[src/obda_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module obda_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/obda_seq.sv]
`timescale 1ns / 1ps
// Sequencer and datapath: book RAM, pick buffer, shared adder, result hold
// and output register. Depends on obda_pkg, obda_if, obda_alu, obda_ram.
`include "order_book_depth_aggregator_defines.svh"

module obda_seq import obda_pkg::*; #(
   parameter int PRICE_LEVELS = 1024,
   parameter int MAX_DEPTH    = 32,
   localparam int DW = $clog2(MAX_DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   obda_req_if.sink      req_chan,
   obda_rsp_if.source    rsp_chan,
   input  logic [DW-1:0] depth_eff
);

   localparam int PW = $clog2(PRICE_LEVELS);
   localparam int AW = PW + 1;
   localparam int BW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int ENTRY_W = $bits(book_entry_type);
   localparam logic [PW:0] PL_VAL = (PW + 1)'(PRICE_LEVELS);

   typedef enum logic [8:0] {
      ST_CLEAR     = 9'b000000001,
      ST_IDLE      = 9'b000000010,
      ST_ADD_WR    = 9'b000000100,
      ST_SELL_SCAN = 9'b000001000,
      ST_SE_PICK   = 9'b000010000,
      ST_SE_BOOK   = 9'b000100000,
      ST_SE_OUT    = 9'b001000000,
      ST_BUY_SCAN  = 9'b010000000,
      ST_FINISH    = 9'b100000000
   } state_type;

   // control registers
   state_type        state_ff, state_in;
   logic [AW-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [PW:0]      scan_ptr_ff, scan_ptr_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [DW-1:0]    picked_ff, picked_in;
   logic [DW-1:0]    emit_idx_ff, emit_idx_in;
   logic             hold_valid_ff, hold_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [PW-1:0]       rd_price_ff, rd_price_in;
   logic [PW-1:0]       lv_ff, lv_in;
   logic                add_side_ff, add_side_in;
   logic [PW-1:0]       add_price_ff, add_price_in;
   logic [VOL_IN_W-1:0] add_vol_ff, add_vol_in;
   logic                hold_side_ff, hold_side_in;
   logic [PW-1:0]       hold_price_ff, hold_price_in;
   logic [VOL_W-1:0]    hold_vol_ff, hold_vol_in;
   logic                rsp_side_ff, rsp_side_in;
   logic [PRICE_W-1:0]  rsp_price_ff, rsp_price_in;
   logic [VOL_W-1:0]    rsp_vol_ff, rsp_vol_in;
   logic                rsp_empty_ff, rsp_empty_in;
   logic                rsp_last_ff, rsp_last_in;

   // RAM ports
   logic           book_we;
   logic [AW-1:0]  book_waddr, book_raddr;
   book_entry_type book_wdata, book_rd;
   logic [ENTRY_W-1:0] book_rdata;
   logic           pb_we;
   logic [BW-1:0]  pb_waddr, pb_raddr;
   logic [PW-1:0]  pb_wdata, pb_rdata;

   // shared adder
   alu_op_type       alu_op;
   logic [VOL_W-1:0] alu_res;

   // misc
   logic [31:0]   req_price_wide, hold_price_wide;
   logic [PW-1:0] req_idx;
   logic          req_in_range;
   logic          out_free, can_emit, scan_hit, buy_stall, scan_issue;
   logic [DW-1:0] picked_next;
   logic          emit, emit_side;
   logic [PW-1:0] emit_price;
   logic [VOL_W-1:0] emit_vol;
   logic          push, push_last, push_empty;

   obda_alu u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   // book: {side, price} -> {present, volume}
   obda_ram #(.WIDTH(ENTRY_W), .DEPTH(2 ** AW)) u_book_ram (
      .clock (clock),
      .we    (book_we),
      .waddr (book_waddr),
      .wdata (book_wdata),
      .raddr (book_raddr),
      .rdata (book_rdata)
   );

   // lowest touched sell levels of the current report
   obda_ram #(.WIDTH(PW), .DEPTH(2 ** BW)) u_pick_ram (
      .clock (clock),
      .we    (pb_we),
      .waddr (pb_waddr),
      .wdata (pb_wdata),
      .raddr (pb_raddr),
      .rdata (pb_rdata)
   );

   assign book_rd = book_rdata;

   // request price mapped onto the table index
   assign req_price_wide  = 32'(req_chan.price);
   assign req_idx         = req_price_wide[PW-1:0];
   assign req_in_range    = req_price_wide < 32'(PRICE_LEVELS);
   assign hold_price_wide = 32'(hold_price_ff);

   // emit a level: needs the output register only when one is already held
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign can_emit    = !hold_valid_ff || out_free;
   assign scan_hit    = rd_valid_ff && book_rd.present;
   assign buy_stall   = scan_hit && !can_emit;
   assign picked_next = picked_ff + DW'(scan_hit);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      scan_ptr_in   = scan_ptr_ff;
      rd_valid_in   = rd_valid_ff;
      picked_in     = picked_ff;
      emit_idx_in   = emit_idx_ff;
      rd_price_in   = rd_price_ff;
      lv_in         = lv_ff;
      add_side_in   = add_side_ff;
      add_price_in  = add_price_ff;
      add_vol_in    = add_vol_ff;
      book_we       = 1'b0;
      book_waddr    = '0;
      book_wdata    = '0;
      book_raddr    = '0;
      pb_we         = 1'b0;
      pb_waddr      = '0;
      pb_wdata      = '0;
      pb_raddr      = '0;
      alu_op        = '0;
      scan_issue    = 1'b0;
      emit          = 1'b0;
      emit_side     = SIDE_BUY;
      emit_price    = '0;
      emit_vol      = '0;
      push          = 1'b0;
      push_last     = 1'b0;
      push_empty    = 1'b0;
      req_chan.ready = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            book_we    = 1'b1;
            book_waddr = clr_cnt_ff;
            alu_op     = '{a: 32'(clr_cnt_ff), b: 32'd1, sat: 1'b0};
            clr_cnt_in = alu_res[AW-1:0];
            if (&clr_cnt_ff) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_chan.ready = 1'b1;
            book_raddr     = {req_chan.side, req_idx};
            if (req_chan.valid) begin
               unique case (req_chan.command)
                  CMD_ADD: begin
                     add_side_in  = req_chan.side;
                     add_price_in = req_idx;
                     add_vol_in   = req_chan.volume;
                     if (req_in_range) begin
                        state_in = ST_ADD_WR;
                     end
                  end
                  CMD_REPORT: begin
                     scan_ptr_in = '0;
                     rd_valid_in = 1'b0;
                     picked_in   = '0;
                     state_in    = ST_SELL_SCAN;
                  end
                  CMD_CLEAR: begin
                     clr_cnt_in = '0;
                     state_in   = ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end

         // read data of the accepted add is here now
         ST_ADD_WR: begin
            alu_op     = '{a: book_rd.volume, b: 32'(add_vol_ff), sat: 1'b1};
            book_we    = 1'b1;
            book_waddr = {add_side_ff, add_price_ff};
            book_wdata = '{present: 1'b1, volume: alu_res};
            state_in   = ST_IDLE;
         end

         // ascending sell scan, one read in flight
         ST_SELL_SCAN: begin
            if (scan_hit) begin
               pb_we    = 1'b1;
               pb_waddr = picked_ff[BW-1:0];
               pb_wdata = rd_price_ff;
            end
            alu_op      = '{a: 32'(scan_ptr_ff), b: 32'd1, sat: 1'b0};
            scan_issue  = scan_ptr_ff < PL_VAL;
            book_raddr  = {SIDE_SELL, scan_ptr_ff[PW-1:0]};
            rd_price_in = scan_ptr_ff[PW-1:0];
            if (picked_next == depth_eff || !scan_issue) begin
               rd_valid_in = 1'b0;
               emit_idx_in = picked_next;
               picked_in   = '0;
               if (picked_next == '0) begin
                  scan_ptr_in = PL_VAL;
                  state_in    = ST_BUY_SCAN;
               end else begin
                  state_in = ST_SE_PICK;
               end
            end else begin
               scan_ptr_in = alu_res[PW:0];
               rd_valid_in = 1'b1;
               picked_in   = picked_next;
            end
         end

         ST_SE_PICK: begin
            alu_op      = '{a: 32'(emit_idx_ff), b: '1, sat: 1'b0};
            emit_idx_in = alu_res[DW-1:0];
            pb_raddr    = alu_res[BW-1:0];
            state_in    = ST_SE_BOOK;
         end

         ST_SE_BOOK: begin
            lv_in      = pb_rdata;
            book_raddr = {SIDE_SELL, pb_rdata};
            state_in   = ST_SE_OUT;
         end

         // keep the read address so the data holds across a stall
         ST_SE_OUT: begin
            book_raddr = {SIDE_SELL, lv_ff};
            if (can_emit) begin
               emit       = 1'b1;
               emit_side  = SIDE_SELL;
               emit_price = lv_ff;
               emit_vol   = book_rd.volume;
               if (emit_idx_ff == '0) begin
                  scan_ptr_in = PL_VAL;
                  rd_valid_in = 1'b0;
                  picked_in   = '0;
                  state_in    = ST_BUY_SCAN;
               end else begin
                  state_in = ST_SE_PICK;
               end
            end
         end

         // descending buy scan, emits straight from the read data
         ST_BUY_SCAN: begin
            if (buy_stall) begin
               book_raddr = {SIDE_BUY, rd_price_ff};
            end else begin
               if (scan_hit) begin
                  emit       = 1'b1;
                  emit_side  = SIDE_BUY;
                  emit_price = rd_price_ff;
                  emit_vol   = book_rd.volume;
               end
               alu_op      = '{a: 32'(scan_ptr_ff), b: '1, sat: 1'b0};
               scan_issue  = scan_ptr_ff != '0;
               book_raddr  = {SIDE_BUY, alu_res[PW-1:0]};
               rd_price_in = alu_res[PW-1:0];
               if (picked_next == depth_eff || !scan_issue) begin
                  rd_valid_in = 1'b0;
                  state_in    = ST_FINISH;
               end else begin
                  scan_ptr_in = alu_res[PW:0];
                  rd_valid_in = 1'b1;
                  picked_in   = picked_next;
               end
            end
         end

         // release the held level as last, or the empty-book beat
         ST_FINISH: begin
            if (out_free) begin
               push       = 1'b1;
               push_last  = 1'b1;
               push_empty = !hold_valid_ff;
               state_in   = ST_IDLE;
            end
         end

         default: begin
            clr_cnt_in = '0;
            state_in   = ST_CLEAR;
         end
      endcase
   end

   // hold one level back so the last flag is known when it leaves
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_side_in  = hold_side_ff;
      hold_price_in = hold_price_ff;
      hold_vol_in   = hold_vol_ff;
      if (emit) begin
         hold_valid_in = 1'b1;
         hold_side_in  = emit_side;
         hold_price_in = emit_price;
         hold_vol_in   = emit_vol;
      end else if (push) begin
         hold_valid_in = 1'b0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_side_in  = rsp_side_ff;
      rsp_price_in = rsp_price_ff;
      rsp_vol_in   = rsp_vol_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_last_in  = rsp_last_ff;
      if (push || (emit && hold_valid_ff)) begin
         rsp_valid_in = 1'b1;
         rsp_side_in  = push_empty ? 1'b0 : hold_side_ff;
         rsp_price_in = push_empty ? '0 : hold_price_wide[PRICE_W-1:0];
         rsp_vol_in   = push_empty ? '0 : hold_vol_ff;
         rsp_empty_in = push_empty;
         rsp_last_in  = push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         scan_ptr_ff   <= '0;
         rd_valid_ff   <= 1'b0;
         picked_ff     <= '0;
         emit_idx_ff   <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         scan_ptr_ff   <= scan_ptr_in;
         rd_valid_ff   <= rd_valid_in;
         picked_ff     <= picked_in;
         emit_idx_ff   <= emit_idx_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_price_ff   <= rd_price_in;
      lv_ff         <= lv_in;
      add_side_ff   <= add_side_in;
      add_price_ff  <= add_price_in;
      add_vol_ff    <= add_vol_in;
      hold_side_ff  <= hold_side_in;
      hold_price_ff <= hold_price_in;
      hold_vol_ff   <= hold_vol_in;
      rsp_side_ff   <= rsp_side_in;
      rsp_price_ff  <= rsp_price_in;
      rsp_vol_ff    <= rsp_vol_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.side_res   = rsp_side_ff;
   assign rsp_chan.price_res  = rsp_price_ff;
   assign rsp_chan.volume_res = rsp_vol_ff;
   assign rsp_chan.empty_res  = rsp_empty_ff;
   assign rsp_chan.last       = rsp_last_ff;

   // checks
   `OBDA_ASSERT_IMP(a_idle_no_hold, state_ff == ST_IDLE, !hold_valid_ff, "level still held in idle")
   `OBDA_ASSERT_IMP(a_mid_has_hold, rsp_valid_ff && !rsp_last_ff, hold_valid_ff, "non-last beat without successor")
   `OBDA_ASSERT_IMP(a_empty_is_last, rsp_valid_ff && rsp_empty_ff, rsp_last_ff, "empty beat not last")
   `OBDA_ASSERT_NXT(a_buy_stall_hold, state_ff == ST_BUY_SCAN && buy_stall, $stable(scan_ptr_ff) && state_ff == ST_BUY_SCAN, "buy scan moved while stalled")

endmodule
